>>> hdl/rapq_pkg.sv
// ----------------------------------------------------------------------------
// rapq_pkg
// Shared constants, codes and types of the range-add / point-query block.
// ----------------------------------------------------------------------------
package rapq_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int POS_W       = $clog2(MAX_ENTRIES);
    localparam int NODE_W      = POS_W + 1;
    localparam int LEN_W       = POS_W + 1;
    localparam int TREE_DEPTH  = 2 * MAX_ENTRIES;
    localparam int DATA_W      = 64;
    localparam int CFG_W       = 11;
    localparam int PADDR_W     = 2;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_LEN = PADDR_W'(0);

    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_ENTRIES);
    localparam logic [LEN_W-1:0] LEN_RESET =
        LEN_W'((MAX_ENTRIES < 1024) ? MAX_ENTRIES : 1024);

    typedef struct packed {
        logic              start;
        logic              prefix;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] delta;
    } t_tree_cmd;

    typedef struct packed {
        logic ready;
        logic done;
    } t_tree_stat;

    // low CFG_W bits only: zero is taken as one, above the array size as its size
    function automatic logic [LEN_W-1:0] clamp_len(input logic [PDATA_W-1:0] wdata);
        logic [CFG_W-1:0] raw;
        logic [LEN_W-1:0] res;
        raw = wdata[CFG_W-1:0];
        if (raw == '0) begin
            res = LEN_W'(1);
        end else if (CFG_W'(raw) > CFG_W'(LEN_MAX)) begin
            res = LEN_MAX;
        end else begin
            res = LEN_W'(raw);
        end
        return res;
    endfunction

endpackage

>>> hdl/rapq_tree.sv
// ----------------------------------------------------------------------------
// rapq_tree
// Sum tree over the difference array, held in one synchronous RAM. Walks one
// level per cycle: leaf-to-root read-modify-write for an add, left-sibling
// accumulation for a prefix sum. Clears itself after reset.
// ----------------------------------------------------------------------------
module rapq_tree (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rapq_pkg::t_tree_cmd         i_cmd,
    output rapq_pkg::t_tree_stat        o_stat,
    output logic [rapq_pkg::DATA_W-1:0] o_sum
);

    logic [rapq_pkg::DATA_W-1:0] mem_tree [0:rapq_pkg::TREE_DEPTH-1];

    logic                         r_clearing;
    logic [rapq_pkg::NODE_W-1:0]  r_clr_addr;
    logic                         r_walk;
    logic                         r_first;
    logic                         r_prefix;
    logic [rapq_pkg::NODE_W-1:0]  r_node;
    logic [rapq_pkg::DATA_W-1:0]  r_delta;
    logic                         r_s1_valid;
    logic                         r_s1_last;
    logic                         r_s1_use;
    logic [rapq_pkg::NODE_W-1:0]  r_s1_addr;
    logic                         r_done;
    logic [rapq_pkg::DATA_W-1:0]  r_acc;
    logic [rapq_pkg::DATA_W-1:0]  r_rdata;

    logic [rapq_pkg::NODE_W-1:0]  rd_addr;
    logic                         rd_use;
    logic                         rd_last;
    logic [rapq_pkg::NODE_W-1:0]  n_node;
    logic                         wr_en;
    logic [rapq_pkg::NODE_W-1:0]  wr_addr;
    logic [rapq_pkg::DATA_W-1:0]  wr_data;

    // prefix walk: leaf first, then the left sibling wherever the path is a right child
    always_comb begin
        if (r_prefix && !r_first) begin
            rd_addr = {r_node[rapq_pkg::NODE_W-1:1], 1'b0};
            rd_use  = r_node[0];
            rd_last = (r_node[rapq_pkg::NODE_W-1:1] == (rapq_pkg::NODE_W-1)'(1));
            n_node  = r_node >> 1;
        end else begin
            rd_addr = r_node;
            rd_use  = 1'b1;
            rd_last = !r_prefix && (r_node == rapq_pkg::NODE_W'(1));
            n_node  = r_prefix ? r_node : (r_node >> 1);
        end
    end

    always_comb begin
        wr_en   = r_clearing || (r_s1_valid && !r_prefix);
        wr_addr = r_clearing ? r_clr_addr : r_s1_addr;
        wr_data = r_clearing ? '0 : (r_rdata + r_delta);
    end

    always_ff @(posedge i_clk) begin
        if (r_walk) begin
            r_rdata <= mem_tree[rd_addr];
        end
        if (wr_en) begin
            mem_tree[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_walk     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + rapq_pkg::NODE_W'(1);
                if (r_clr_addr == rapq_pkg::NODE_W'(rapq_pkg::TREE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cmd.start) begin
                r_walk <= 1'b1;
            end else if (r_walk && rd_last) begin
                r_walk <= 1'b0;
            end
            r_s1_valid <= r_walk;
            r_s1_last  <= r_walk && rd_last;
            r_done     <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_prefix <= i_cmd.prefix;
            r_first  <= 1'b1;
            r_node   <= rapq_pkg::NODE_W'(rapq_pkg::MAX_ENTRIES)
                        + rapq_pkg::NODE_W'(i_cmd.pos);
            r_delta  <= i_cmd.delta;
            r_acc    <= '0;
        end else begin
            if (r_walk) begin
                r_node  <= n_node;
                r_first <= 1'b0;
            end
            if (r_s1_valid && r_prefix && r_s1_use) begin
                r_acc <= r_acc + r_rdata;
            end
        end
        r_s1_addr <= rd_addr;
        r_s1_use  <= rd_use;
    end

    assign o_stat.ready = !r_clearing && !r_walk && !r_s1_valid;
    assign o_stat.done  = r_done;
    assign o_sum        = r_acc;

endmodule

>>> hdl/range_add_point_query_top.sv
// ----------------------------------------------------------------------------
// range_add_point_query_top
// Range add / point query over 1024 positions with 64-bit wrapping values.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 2048-entry tree RAM to zero, one entry per
// cycle, and takes no request until the sweep ends (array_length writes are
// taken). An in-range load is written to the base store as it is taken. A
// range add walks the tree from the leaf to the root through the RAM, one
// level per cycle, and walks it again for the subtraction at last+1 unless
// last+1 equals the array length. A point query reads the tree 11 times for
// the prefix sum and then adds the base value. The result sits in an output
// register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module range_add_point_query_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [9:0]                   i_position_a,
    input  logic [9:0]                   i_position_b,
    input  logic signed [63:0]           i_amount,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [63:0]           o_point_value,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rapq_pkg::PADDR_W-1:0] paddr,
    input  logic [rapq_pkg::PDATA_W-1:0] pwdata,
    output logic [rapq_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD_A  = 3'd1;
    localparam logic [2:0] S_ADD_B  = 3'd2;
    localparam logic [2:0] S_QUERY  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [rapq_pkg::DATA_W-1:0] mem_base [0:rapq_pkg::MAX_ENTRIES-1];

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [rapq_pkg::LEN_W-1:0]   r_len;
    logic [rapq_pkg::POS_W-1:0]   r_pb_next;
    logic                         r_skip_b;
    logic [rapq_pkg::DATA_W-1:0]  r_amount;
    logic [rapq_pkg::DATA_W-1:0]  r_base_q;
    logic [rapq_pkg::DATA_W-1:0]  r_value;
    logic                         r_out_valid;
    logic [rapq_pkg::DATA_W-1:0]  r_out_value;

    rapq_pkg::t_tree_cmd          tree_cmd;
    rapq_pkg::t_tree_stat         tree_stat;
    logic [rapq_pkg::DATA_W-1:0]  tree_sum;

    logic                         in_accept;
    logic                         pa_ok;
    logic                         pb_ok;
    logic [rapq_pkg::LEN_W-1:0]   pb_plus1;
    logic                         out_free;
    logic                         cfg_wr;

    assign o_in_ready = (r_state == S_IDLE) && tree_stat.ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign pa_ok      = rapq_pkg::LEN_W'(i_position_a) < r_len;
    assign pb_ok      = rapq_pkg::LEN_W'(i_position_b) < r_len;
    assign pb_plus1   = rapq_pkg::LEN_W'(i_position_b) + rapq_pkg::LEN_W'(1);
    assign out_free   = !r_out_valid || i_out_ready;
    assign cfg_wr     = psel && penable && pwrite && pready && (paddr == rapq_pkg::ADDR_LEN);

    assign pready = 1'b1;
    assign prdata = rapq_pkg::PDATA_W'(r_len);

    rapq_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tree_cmd),
        .o_stat  (tree_stat),
        .o_sum   (tree_sum)
    );

    always_comb begin
        tree_cmd        = '0;
        tree_cmd.pos    = i_position_a;
        tree_cmd.delta  = $unsigned(i_amount);
        n_state         = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_opcode)
                        rapq_pkg::OP_ADD: begin
                            if (pa_ok && pb_ok) begin
                                tree_cmd.start = 1'b1;
                                n_state        = S_ADD_A;
                            end
                        end
                        rapq_pkg::OP_QUERY: begin
                            if (pa_ok) begin
                                tree_cmd.start  = 1'b1;
                                tree_cmd.prefix = 1'b1;
                                n_state         = S_QUERY;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_A: begin
                if (tree_stat.done) begin
                    if (r_skip_b) begin
                        n_state = S_IDLE;
                    end else begin
                        tree_cmd.start = 1'b1;
                        tree_cmd.pos   = r_pb_next;
                        tree_cmd.delta = rapq_pkg::DATA_W'(0) - r_amount;
                        n_state        = S_ADD_B;
                    end
                end
            end
            S_ADD_B: begin
                if (tree_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            S_QUERY: begin
                if (tree_stat.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // base store, never cleared; user must read only loaded entries, unchecked
    always_ff @(posedge i_clk) begin
        if (in_accept && (i_opcode == rapq_pkg::OP_LOAD) && pa_ok) begin
            mem_base[i_position_a] <= $unsigned(i_amount);
        end
        if (in_accept && (i_opcode == rapq_pkg::OP_QUERY) && pa_ok) begin
            r_base_q <= mem_base[i_position_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= rapq_pkg::LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_len <= rapq_pkg::clamp_len(pwdata);
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_amount  <= $unsigned(i_amount);
            r_pb_next <= pb_plus1[rapq_pkg::POS_W-1:0];
            r_skip_b  <= (pb_plus1 == r_len);
            r_value   <= '0;
        end else if (r_state == S_QUERY && tree_stat.done) begin
            r_value <= r_base_q + tree_sum;
        end
        if (r_state == S_FINISH && out_free) begin
            r_out_value <= r_value;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_value = $signed(r_out_value);

endmodule

>>> hdl/rapq_chk.sv
// ----------------------------------------------------------------------------
// rapq_chk
// Port-level checks of the range-add / point-query block, bound to the top.
// ----------------------------------------------------------------------------
module rapq_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [1:0]                   i_opcode,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic signed [63:0]           o_point_value,
    input logic [rapq_pkg::PDATA_W-1:0] prdata,
    input logic                         pready
);

    // the tree RAM is being swept right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken while tree RAM is clearing");

    // a query always leaves the block busy once it has been taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == rapq_pkg::OP_QUERY) |=> !o_in_ready)
        else $error("request taken right after a query");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_point_value))
        else $error("result dropped or changed while stalled");

    // length register reads back within 1..array size
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (prdata != '0)
        && (prdata <= rapq_pkg::PDATA_W'(rapq_pkg::MAX_ENTRIES)))
        else $error("array length out of range or pready low");

endmodule

bind range_add_point_query_top rapq_chk u_rapq_chk (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_add_point_query_top. A short list of directed
// requests and length settings runs first, then phases of random loads, range
// adds, point queries and unused opcodes under several array lengths. Each point
// query is predicted from a difference array and base values kept beside the block
// or set directly, and compared against the returned point_value, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [63:0] S64_MIN     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_WAIT   = 64;
    localparam int          PHASE_ITEMS = 150;
    localparam int          CYCLE_LIMIT = 1_000_000;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [1:0]                     opcode    = '0;
    logic [9:0]                     pos_a     = '0;
    logic [9:0]                     pos_b     = '0;
    logic [63:0]                    amount    = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [63:0]                    point_value;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [rapq_pkg::PADDR_W-1:0]   paddr     = '0;
    logic [rapq_pkg::PDATA_W-1:0]   pwdata    = '0;
    logic [rapq_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    range_add_point_query_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_position_a  (pos_a),
        .i_position_b  (pos_b),
        .i_amount      (amount),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_point_value (point_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: base values plus a plain difference array
    // ------------------------------------------------------------------
    logic [63:0]  base_mem [rapq_pkg::MAX_ENTRIES];
    logic [63:0]  diff_mem [rapq_pkg::MAX_ENTRIES];
    bit           was_loaded [rapq_pkg::MAX_ENTRIES];
    int           loaded_pos_q[$];
    int unsigned  cur_len = rapq_pkg::MAX_ENTRIES;
    logic [63:0]  point_value_q[$];
    int           error_count = 0;
    int           burst_left  = 0;
    int           cycle_count = 0;

    typedef struct {
        bit          cfg;
        logic [1:0]  op;
        logic [9:0]  pa;
        logic [9:0]  pb;
        logic [63:0] amt;
        bit          typed;
        logic [63:0] want;
    } t_step;

    t_step directed_steps[$];

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [63:0] prefix_sum(input int unsigned pos);
        logic [63:0] acc;
        acc = '0;
        for (int i = 0; i <= pos; i++) begin
            acc += diff_mem[i];
        end
        return acc;
    endfunction

    // updates predictor state for one request; has_val set for a query
    task automatic apply_request(input logic [1:0] op, input logic [9:0] pa,
                                 input logic [9:0] pb, input logic [63:0] amt,
                                 output bit has_val, output logic [63:0] val);
        has_val = 1'b0;
        val     = '0;
        case (op)
            rapq_pkg::OP_LOAD: begin
                if (pa < cur_len) begin
                    base_mem[pa] = amt;
                    if (!was_loaded[pa]) begin
                        was_loaded[pa] = 1'b1;
                        loaded_pos_q.push_back(int'(pa));
                    end
                end
            end
            rapq_pkg::OP_ADD: begin
                if (pa < cur_len && pb < cur_len) begin
                    diff_mem[pa] += amt;
                    if (pb + 1 != cur_len) diff_mem[pb + 1] -= amt;
                end
            end
            rapq_pkg::OP_QUERY: begin
                has_val = 1'b1;
                if (pa < cur_len) val = base_mem[pa] + prefix_sum(pa);
            end
            default: ;
        endcase
    endtask

    // one request through the valid/ready handshake, sender idles in bursts
    task automatic send_request(input logic [1:0] op, input logic [9:0] pa,
                                input logic [9:0] pb, input logic [63:0] amt,
                                input bit typed, input logic [63:0] want);
        int          gap;
        bit          has_val;
        logic [63:0] val;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        pos_a    <= pa;
        pos_b    <= pb;
        amount   <= amt;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        burst_left--;
        apply_request(op, pa, pb, amt, has_val, val);
        if (has_val) point_value_q.push_back(typed ? want : val);
    endtask

    // array_length write, only once the block has drained
    task automatic write_length(input logic [31:0] value);
        int unsigned raw;
        in_valid <= 1'b0;
        while (point_value_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rapq_pkg::ADDR_LEN;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        raw = 32'(value[rapq_pkg::CFG_W-1:0]);
        if (raw == 0) raw = 1;
        if (raw > rapq_pkg::MAX_ENTRIES) raw = rapq_pkg::MAX_ENTRIES;
        cur_len = raw;
    endtask

    function automatic t_step step_op(input logic [1:0] op, input logic [9:0] pa,
                                      input logic [9:0] pb, input logic [63:0] amt);
        t_step s;
        s = '{cfg: 1'b0, op: op, pa: pa, pb: pb, amt: amt, typed: 1'b0, want: '0};
        return s;
    endfunction

    function automatic t_step step_chk(input logic [9:0] pa, input logic [63:0] want);
        t_step s;
        s = '{cfg: 1'b0, op: rapq_pkg::OP_QUERY, pa: pa, pb: '0, amt: '0, typed: 1'b1,
              want: want};
        return s;
    endfunction

    function automatic t_step step_cfg(input logic [31:0] value);
        t_step s;
        s = '{cfg: 1'b1, op: rapq_pkg::OP_LOAD, pa: '0, pb: '0, amt: 64'(value),
              typed: 1'b0, want: '0};
        return s;
    endfunction

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid === 1'b1 && out_ready) begin
            if (point_value_q.size() == 0) begin
                report($sformatf("unexpected result point_value=%h", point_value));
            end else begin
                if (point_value !== point_value_q[0]) begin
                    report($sformatf("point_value got %h want %h",
                                     point_value, point_value_q[0]));
                end
                void'(point_value_q.pop_front());
            end
        end
    end

    // receiver stall pattern, switches between four modes at random
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 0);
            2:       out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, point_value_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] phase_len [8];
        int          r;
        logic [1:0]  op;
        logic [9:0]  pa;
        logic [9:0]  pb;
        logic [63:0] amt;

        for (int i = 0; i < rapq_pkg::MAX_ENTRIES; i++) begin
            base_mem[i]   = '0;
            diff_mem[i]   = '0;
            was_loaded[i] = 1'b0;
        end

        // reset length 1024: extremes, full-range add, reversed ranges
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd0, 10'd1023, S64_MIN));
        directed_steps.push_back(step_chk(10'd0, S64_MIN));
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd1023, 10'd0, S64_MAX));
        directed_steps.push_back(step_chk(10'd1023, S64_MAX));
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd5, 10'd5, ALL_ONES));
        directed_steps.push_back(step_chk(10'd5, ALL_ONES));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd0, 10'd1023, 64'd1));
        directed_steps.push_back(step_chk(10'd1023, S64_MIN));
        directed_steps.push_back(step_chk(10'd0, S64_MIN + 64'd1));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd1, 10'd3, 64'd10));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd6, 10'd2, 64'd100));
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd3, 10'd0, 64'd0));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd3, 10'd0, 64'd0));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd5, 10'd1023, ALL_ONES));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd1023, 10'd0, S64_MAX));
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd2, 10'd0,
                                         64'h0123_4567_89AB_CDEF));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd2, 10'd0, 64'd0));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd1023, 10'd0, 64'd0));
        directed_steps.push_back(step_op(OP_UNUSED, 10'd1023, 10'd1023, ALL_ONES));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd512, 10'd511, S64_MIN));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd1023, 10'd0, 64'd0));
        // zero length is taken as one: out-of-range loads, adds and queries
        directed_steps.push_back(step_cfg(32'd0));
        directed_steps.push_back(step_op(rapq_pkg::OP_LOAD, 10'd1, 10'd0, 64'd77));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd0, 10'd1, 64'd50));
        directed_steps.push_back(step_op(rapq_pkg::OP_ADD, 10'd0, 10'd0, 64'd3));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd0, 10'd0, 64'd0));
        directed_steps.push_back(step_chk(10'd1, 64'd0));
        directed_steps.push_back(step_chk(10'd1023, 64'd0));
        // oversize length with junk upper bits clamps to the array size
        directed_steps.push_back(step_cfg(32'hFFFF_FFFF));
        directed_steps.push_back(step_op(rapq_pkg::OP_QUERY, 10'd5, 10'd0, 64'd0));

        phase_len[0] = 32'd2;
        phase_len[1] = 32'd1024;
        phase_len[2] = 32'($urandom_range(3, 1022));
        phase_len[3] = 32'd1;
        phase_len[4] = 32'd1023;
        phase_len[5] = {21'h1F_FFFF, 11'd700};
        phase_len[6] = 32'd1500;
        phase_len[7] = 32'($urandom_range(8, 64));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].cfg) begin
                write_length(directed_steps[i].amt[31:0]);
            end else begin
                send_request(directed_steps[i].op, directed_steps[i].pa,
                             directed_steps[i].pb, directed_steps[i].amt,
                             directed_steps[i].typed, directed_steps[i].want);
            end
        end

        foreach (phase_len[ph]) begin
            write_length(phase_len[ph]);
            repeat (PHASE_ITEMS) begin
                r  = $urandom_range(0, 99);
                pa = 10'($urandom_range(0, cur_len - 1));
                pb = 10'($urandom_range(0, cur_len - 1));
                case ($urandom_range(0, 9))
                    0:       amt = S64_MIN;
                    1:       amt = S64_MAX;
                    2:       amt = ALL_ONES;
                    3:       amt = '0;
                    4, 5:    amt = 64'($urandom_range(0, 200)) - 64'd100;
                    default: amt = {$urandom, $urandom};
                endcase
                if (r < 30) begin
                    op = rapq_pkg::OP_LOAD;
                    if ($urandom_range(0, 9) == 0) pa = 10'($urandom);
                    pb = 10'($urandom);
                end else if (r < 60) begin
                    op = rapq_pkg::OP_ADD;
                    if ($urandom_range(0, 9) == 0) pa = 10'($urandom);
                    if ($urandom_range(0, 9) == 0) pb = 10'($urandom);
                end else if (r < 95) begin
                    op = rapq_pkg::OP_QUERY;
                    pb = 10'($urandom);
                    if (loaded_pos_q.size() > 0 && $urandom_range(0, 4) != 0) begin
                        pa = 10'(loaded_pos_q[$urandom_range(0, loaded_pos_q.size() - 1)]);
                    end else begin
                        pa = 10'($urandom);
                    end
                    // never read a base value that was not loaded
                    if (pa < cur_len && !was_loaded[pa]) op = rapq_pkg::OP_LOAD;
                end else begin
                    op = OP_UNUSED;
                    pa = 10'($urandom);
                    pb = 10'($urandom);
                end
                send_request(op, pa, pb, amt, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (point_value_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rapq_pkg.sv
hdl/rapq_tree.sv
hdl/range_add_point_query_top.sv
hdl/rapq_chk.sv
verif/tb_top.sv
